FILE: src/cus_pkg.sv
// Shared types, constants and blend arithmetic for the chroma upsampler.
package cus_pkg;

  // Frame limits and field widths
  localparam int MAX_CHROMA_WIDTH  = 2048;
  localparam int MAX_CHROMA_HEIGHT = 2048;
  localparam int DIM_W      = 12;
  localparam int COL_CNT_W  = $clog2(MAX_CHROMA_WIDTH);
  localparam int ROW_CNT_W  = $clog2(MAX_CHROMA_HEIGHT);
  localparam int POS_W      = 12;
  localparam int SAMPLE_W   = 8;
  localparam int PAIR_W     = 2 * SAMPLE_W;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  // Reset values of the frame size registers
  localparam logic [DIM_W-1:0] RST_CHROMA_WIDTH  = 12'd960;
  localparam logic [DIM_W-1:0] RST_CHROMA_HEIGHT = 12'd540;

  // Tap kinds: edge repeat, 3:1 toward left/above, 1:3 toward current
  localparam logic [1:0] TAP_EDGE = 2'd0;
  localparam logic [1:0] TAP_LO   = 2'd1;
  localparam logic [1:0] TAP_HI   = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] u_in;
    logic [SAMPLE_W-1:0] v_in;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] cb_out;
    logic [SAMPLE_W-1:0] cr_out;
    logic [POS_W-1:0]    pixel_row;
    logic [POS_W-1:0]    pixel_col;
    logic                run_last;
  } out_t;

  // One chroma position with its neighbors and its place in the frame
  typedef struct packed {
    logic [PAIR_W-1:0] cur;         // Cb low, Cr high
    logic [PAIR_W-1:0] left;
    logic [PAIR_W-1:0] above;
    logic [PAIR_W-1:0] above_left;
    logic              c_first;
    logic              c_last;
    logic              r_first;
    logic              r_last;
    logic [POS_W-1:0]  col2;        // 2c
    logic [POS_W-1:0]  col_end;     // 2W-1
    logic [POS_W-1:0]  row2;        // 2r
    logic [POS_W-1:0]  row_end;     // 2H-1
  } item_t;

  // Horizontal blend of one component, four times the sample scale
  function automatic logic [9:0] hsum(input logic [SAMPLE_W-1:0] l,
                                      input logic [SAMPLE_W-1:0] c,
                                      input logic [1:0] hk);
    logic [9:0] l10;
    logic [9:0] c10;
    l10 = {2'b00, l};
    c10 = {2'b00, c};
    case (hk)
      TAP_LO:  hsum = l10 + (l10 << 1) + c10;
      TAP_HI:  hsum = l10 + c10 + (c10 << 1);
      default: hsum = c10 << 2;
    endcase
  endfunction

  // Full 2-D blend of one component
  function automatic logic [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] l,
                                                input logic [SAMPLE_W-1:0] c,
                                                input logic [SAMPLE_W-1:0] al,
                                                input logic [SAMPLE_W-1:0] a,
                                                input logic [1:0] hk,
                                                input logic [1:0] vk);
    logic [9:0]  hc;
    logic [9:0]  ha;
    logic [12:0] hc13;
    logic [12:0] ha13;
    logic [12:0] acc;
    hc   = hsum(l, c, hk);
    ha   = hsum(al, a, hk);
    hc13 = {3'b000, hc};
    ha13 = {3'b000, ha};
    case (vk)
      TAP_LO:  acc = ha13 + (ha13 << 1) + hc13 + 13'd8;
      TAP_HI:  acc = ha13 + hc13 + (hc13 << 1) + 13'd8;
      default: acc = {1'b0, hc13[12:1]} << 1;
    endcase
    if (vk == TAP_LO || vk == TAP_HI) begin
      blend = acc[11:4];
    end else begin
      blend = hc[9:2];
    end
  endfunction

endpackage

FILE: src/cus_front.sv
// Input stage: frame registers, position counters, chroma line store and neighbor samples.
module cus_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cus_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cus_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cus_pkg::in_t                  in_data,
  output logic                          s1_valid,
  output cus_pkg::item_t                s1_item,
  input  logic                          s1_take
);

  logic [cus_pkg::DIM_W-1:0]     cfg_w_r;
  logic [cus_pkg::DIM_W-1:0]     cfg_h_r;
  logic [cus_pkg::COL_CNT_W-1:0] col_r;
  logic [cus_pkg::COL_CNT_W-1:0] col_nxt;
  logic [cus_pkg::ROW_CNT_W-1:0] row_r;
  logic [cus_pkg::ROW_CNT_W-1:0] row_nxt;
  logic [cus_pkg::PAIR_W-1:0]    lsc_r;
  logic [cus_pkg::PAIR_W-1:0]    lsp_r;
  logic [cus_pkg::PAIR_W-1:0]    above_r;
  logic                          s1_v_r;
  cus_pkg::item_t                s1_r;
  cus_pkg::item_t                s1_nxt;
  logic [cus_pkg::PAIR_W-1:0]    line_mem [cus_pkg::MAX_CHROMA_WIDTH];

  logic [cus_pkg::DIM_W-1:0]     w;
  logic [cus_pkg::DIM_W-1:0]     h;
  logic [cus_pkg::DIM_W-1:0]     w_m1;
  logic [cus_pkg::DIM_W-1:0]     h_m1;
  logic [cus_pkg::COL_CNT_W-1:0] c_eff;
  logic [cus_pkg::ROW_CNT_W-1:0] r_eff;
  logic [cus_pkg::DIM_W-1:0]     c_inc;
  logic [cus_pkg::DIM_W-1:0]     r_inc;
  logic [cus_pkg::PAIR_W-1:0]    cur;
  logic                          accept;
  logic                          cfg_hit;

  // Clamp the frame size to 1..max
  always_comb begin
    if (cfg_w_r == '0) begin
      w = cus_pkg::DIM_W'(1);
    end else if (cfg_w_r > cus_pkg::DIM_W'(cus_pkg::MAX_CHROMA_WIDTH)) begin
      w = cus_pkg::DIM_W'(cus_pkg::MAX_CHROMA_WIDTH);
    end else begin
      w = cfg_w_r;
    end
    if (cfg_h_r == '0) begin
      h = cus_pkg::DIM_W'(1);
    end else if (cfg_h_r > cus_pkg::DIM_W'(cus_pkg::MAX_CHROMA_HEIGHT)) begin
      h = cus_pkg::DIM_W'(cus_pkg::MAX_CHROMA_HEIGHT);
    end else begin
      h = cfg_h_r;
    end
    w_m1 = w - cus_pkg::DIM_W'(1);
    h_m1 = h - cus_pkg::DIM_W'(1);
  end

  // Position of this request inside the frame
  always_comb begin
    c_eff = (cus_pkg::DIM_W'(col_r) >= w) ? w_m1[cus_pkg::COL_CNT_W-1:0] : col_r;
    r_eff = (cus_pkg::DIM_W'(row_r) >= h) ? h_m1[cus_pkg::ROW_CNT_W-1:0] : row_r;
    c_inc = cus_pkg::DIM_W'(c_eff) + cus_pkg::DIM_W'(1);
    r_inc = cus_pkg::DIM_W'(r_eff) + cus_pkg::DIM_W'(1);
    cur   = {in_data.v_in, in_data.u_in};
    if (c_inc >= w) begin
      col_nxt = '0;
      row_nxt = (r_inc >= h) ? '0 : r_inc[cus_pkg::ROW_CNT_W-1:0];
    end else begin
      col_nxt = c_inc[cus_pkg::COL_CNT_W-1:0];
      row_nxt = r_eff;
    end
  end

  // Build the stage record
  always_comb begin
    s1_nxt            = '0;
    s1_nxt.cur        = cur;
    s1_nxt.left       = lsc_r;
    s1_nxt.c_first    = (c_eff == '0);
    s1_nxt.c_last     = (c_inc == w);
    s1_nxt.r_first    = (r_eff == '0);
    s1_nxt.r_last     = (r_inc == h);
    s1_nxt.col2       = cus_pkg::POS_W'({c_eff, 1'b0});
    s1_nxt.col_end    = cus_pkg::POS_W'({w, 1'b0}) - cus_pkg::POS_W'(1);
    s1_nxt.row2       = cus_pkg::POS_W'({r_eff, 1'b0});
    s1_nxt.row_end    = cus_pkg::POS_W'({h, 1'b0}) - cus_pkg::POS_W'(1);
  end

  assign in_ready = !s1_v_r || s1_take;
  assign accept   = in_valid && in_ready;
  assign cfg_hit  = cfg_we &&
                    (cfg_index == cus_pkg::CFG_IDX_WIDTH || cfg_index == cus_pkg::CFG_IDX_HEIGHT);

  // Control: frame registers, counters, stage valid, neighbor samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= cus_pkg::RST_CHROMA_WIDTH;
      cfg_h_r <= cus_pkg::RST_CHROMA_HEIGHT;
      col_r   <= '0;
      row_r   <= '0;
      lsc_r   <= '0;
      lsp_r   <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
        lsc_r  <= cur;
        col_r  <= col_nxt;
        row_r  <= row_nxt;
      end else if (s1_take) begin
        s1_v_r <= 1'b0;
      end
      // Carry the row-above sample along as the next item's above-left
      if (s1_take) begin
        lsp_r <= above_r;
      end
      // Register writes restart the frame
      if (cfg_we) begin
        case (cfg_index)
          cus_pkg::CFG_IDX_WIDTH:  cfg_w_r <= cfg_wdata;
          cus_pkg::CFG_IDX_HEIGHT: cfg_h_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        col_r <= '0;
        row_r <= '0;
      end
    end
  end

  // Line store: read the row above and overwrite it with this sample
  always_ff @(posedge clk) begin
    if (accept) begin
      above_r         <= line_mem[c_eff];
      line_mem[c_eff] <= cur;
      s1_r            <= s1_nxt;
    end
  end

  // Attach the line store outputs
  always_comb begin
    s1_item            = s1_r;
    s1_item.above      = above_r;
    s1_item.above_left = lsp_r;
  end

  assign s1_valid = s1_v_r;

endmodule

FILE: src/cus_expand.sv
// Result sequencer: walks the output pixels of one chroma position and blends each one.
module cus_expand (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s1_valid,
  input  cus_pkg::item_t s1_item,
  output logic           s1_take,
  output logic           out_valid,
  input  logic           out_ready,
  output cus_pkg::out_t  out_data
);

  logic           s2_v_r;
  cus_pkg::item_t it_r;
  logic [1:0]     i_r;
  logic [1:0]     j_r;
  logic           ov_r;
  cus_pkg::out_t  od_r;
  cus_pkg::out_t  od_nxt;

  logic [1:0]                hmax;
  logic [1:0]                vmax;
  logic [1:0]                hk;
  logic [1:0]                vk;
  logic [cus_pkg::POS_W-1:0] col;
  logic [cus_pkg::POS_W-1:0] row;
  logic                      last_j;
  logic                      last_i;
  logic                      out_load;
  logic                      emit;
  logic                      fin;

  // Horizontal tap for the current column step
  always_comb begin
    hmax = it_r.c_first ? (it_r.c_last ? 2'd1 : 2'd0) : (it_r.c_last ? 2'd2 : 2'd1);
    if (it_r.c_first) begin
      hk  = cus_pkg::TAP_EDGE;
      col = (j_r == 2'd0) ? '0 : it_r.col_end;
    end else begin
      case (j_r)
        2'd0: begin
          hk  = cus_pkg::TAP_LO;
          col = it_r.col2 - cus_pkg::POS_W'(1);
        end
        2'd1: begin
          hk  = cus_pkg::TAP_HI;
          col = it_r.col2;
        end
        default: begin
          hk  = cus_pkg::TAP_EDGE;
          col = it_r.col_end;
        end
      endcase
    end
  end

  // Vertical tap for the current row step
  always_comb begin
    vmax = it_r.r_first ? (it_r.r_last ? 2'd1 : 2'd0) : (it_r.r_last ? 2'd2 : 2'd1);
    if (it_r.r_first) begin
      vk  = cus_pkg::TAP_EDGE;
      row = (i_r == 2'd0) ? '0 : it_r.row_end;
    end else begin
      case (i_r)
        2'd0: begin
          vk  = cus_pkg::TAP_LO;
          row = it_r.row2 - cus_pkg::POS_W'(1);
        end
        2'd1: begin
          vk  = cus_pkg::TAP_HI;
          row = it_r.row2;
        end
        default: begin
          vk  = cus_pkg::TAP_EDGE;
          row = it_r.row_end;
        end
      endcase
    end
  end

  // Blend both components of this pixel
  always_comb begin
    last_j           = (j_r == hmax);
    last_i           = (i_r == vmax);
    od_nxt.cb_out    = cus_pkg::blend(it_r.left[7:0], it_r.cur[7:0],
                                      it_r.above_left[7:0], it_r.above[7:0], hk, vk);
    od_nxt.cr_out    = cus_pkg::blend(it_r.left[15:8], it_r.cur[15:8],
                                      it_r.above_left[15:8], it_r.above[15:8], hk, vk);
    od_nxt.pixel_row = row;
    od_nxt.pixel_col = col;
    od_nxt.run_last  = last_i && last_j;
  end

  assign out_load = !ov_r || out_ready;
  assign emit     = s2_v_r && out_load;
  assign fin      = emit && last_i && last_j;
  assign s1_take  = s1_valid && (!s2_v_r || fin);

  // Control: step through the pixel grid and hand results to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      ov_r   <= 1'b0;
      i_r    <= '0;
      j_r    <= '0;
    end else begin
      if (out_load) begin
        ov_r <= s2_v_r;
      end
      if (s1_take) begin
        s2_v_r <= 1'b1;
        i_r    <= '0;
        j_r    <= '0;
      end else if (fin) begin
        s2_v_r <= 1'b0;
      end else if (emit) begin
        if (last_j) begin
          j_r <= '0;
          i_r <= i_r + 2'd1;
        end else begin
          j_r <= j_r + 2'd1;
        end
      end
    end
  end

  // Payload: hold the item, capture each result
  always_ff @(posedge clk) begin
    if (s1_take) begin
      it_r <= s1_item;
    end
    if (emit) begin
      od_r <= od_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

FILE: src/chroma_upsample_420_to_444_unit.sv
// Top level of the 4:2:0 to 4:4:4 chroma upsampler.
// Usage:
//   in_*  : one (Cb,Cr) chroma pair per request, raster order over the chroma frame.
//   out_* : one full-resolution chroma pixel per request with its row and column;
//           run_last marks the last pixel caused by an input pair.
//   cfg_* : write chroma_width (index 0) or chroma_height (index 1) while idle;
//           any such write restarts the frame at row 0, column 0.
// Path: a pair goes through the input register (line store read as the pair is taken),
// then the sequencer load, then the output register that drives out_valid.
// Throughput: one pixel per cycle while out_ready is high. A pair makes from 1 to 9
// pixels; inner pairs make 4. The sequencer, which emits one pixel per cycle, sets
// the rate; the input register takes the next pair while the current one is still
// being emitted.
// Reset: counters go to the frame start, sizes to 960 x 540, no results pending.
// The line store holds no reset value; it is filled by the first chroma row.
// Stall: with out_ready low the output register holds, the sequencer and input
// register fill, and in_ready drops; nothing is lost or repeated.
module chroma_upsample_420_to_444_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cus_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cus_pkg::DIM_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cus_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cus_pkg::out_t                 out_data
);

  logic           s1_valid;
  logic           s1_take;
  cus_pkg::item_t s1_item;

  // Input register, counters and line store
  cus_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (s1_take)
  );

  // Pixel sequencer and output register
  cus_expand u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: src/cus_checker.sv
// Port-level checks for the chroma upsampler, bound to the top level.
module cus_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  cus_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  cus_pkg::out_t                 out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // Nothing pending after reset, and the input side is open
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // A pair's pixels follow back to back, in raster order
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.run_last |=> out_valid &&
      ((out_data.pixel_row > $past(out_data.pixel_row)) ||
       (out_data.pixel_row == $past(out_data.pixel_row) &&
        out_data.pixel_col > $past(out_data.pixel_col))))
    else $error("pixel run broken or out of order");

endmodule

bind chroma_upsample_420_to_444_unit cus_checker u_cus_checker (.*);

FILE: test/tb_chroma_upsample_420_to_444_unit.sv
// Testbench for the 4:2:0 to 4:4:4 chroma upsampler: directed and random frames against a line-store predictor.
`timescale 1ns / 100ps

module tb_chroma_upsample_420_to_444_unit;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int RANDOM_ITEMS     = 390;
  localparam int HOLD_OFF_CYCLES  = 200;
  localparam int END_QUIET_CYCLES = 16;

  // Indexes past the register list; writes there must change nothing
  localparam logic [cus_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [cus_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  // Tracks the chroma frame and holds the pixels each pair should produce
  class pixel_scoreboard;
    logic [cus_pkg::DIM_W-1:0]  width_reg;
    logic [cus_pkg::DIM_W-1:0]  height_reg;
    logic [cus_pkg::PAIR_W-1:0] line_store [cus_pkg::MAX_CHROMA_WIDTH];
    logic [cus_pkg::PAIR_W-1:0] left_cur;
    logic [cus_pkg::PAIR_W-1:0] left_above;
    int unsigned                col_cnt;
    int unsigned                row_cnt;
    cus_pkg::out_t              pending_pixels [$];
    int                         errors;

    function new();
      width_reg  = cus_pkg::RST_CHROMA_WIDTH;
      height_reg = cus_pkg::RST_CHROMA_HEIGHT;
      foreach (line_store[i]) line_store[i] = '0;
      left_cur   = '0;
      left_above = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      errors     = 0;
    endfunction

    // Zero reads as one, anything past the given limit as that limit
    static function int unsigned clamp_dim(input logic [cus_pkg::DIM_W-1:0] v,
                                           input int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return 32'(v);
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    // Size writes restart the frame; spare indexes are ignored
    function void write_cfg(input logic [cus_pkg::CFG_IDX_W-1:0] idx,
                            input logic [cus_pkg::DIM_W-1:0] val);
      case (idx)
        cus_pkg::CFG_IDX_WIDTH: begin
          width_reg = val;
          col_cnt   = 0;
          row_cnt   = 0;
        end
        cus_pkg::CFG_IDX_HEIGHT: begin
          height_reg = val;
          col_cnt    = 0;
          row_cnt    = 0;
        end
        default: begin
        end
      endcase
    endfunction

    // Blend one component; zero vertical weights mean an edge row
    function logic [cus_pkg::SAMPLE_W-1:0] blend_comp(input logic [cus_pkg::SAMPLE_W-1:0] l,
                                                      input logic [cus_pkg::SAMPLE_W-1:0] c,
                                                      input logic [cus_pkg::SAMPLE_W-1:0] al,
                                                      input logic [cus_pkg::SAMPLE_W-1:0] a,
                                                      input int unsigned wl,
                                                      input int unsigned wc,
                                                      input int unsigned wa,
                                                      input int unsigned wv);
      int unsigned hc;
      int unsigned ha;
      int unsigned acc;
      hc = wl * l + wc * c;
      ha = wl * al + wc * a;
      if (wa == 0 && wv == 0) acc = hc >> 2;
      else acc = (wa * ha + wv * hc + 8) >> 4;
      return acc[cus_pkg::SAMPLE_W-1:0];
    endfunction

    // Work out every pixel one accepted pair makes, then advance the frame
    function void note_pair(input cus_pkg::in_t p);
      int unsigned w, h, c, r, nh, nv, i, j;
      int unsigned hcol [3];
      int unsigned hwl  [3];
      int unsigned hwc  [3];
      int unsigned vrow [3];
      int unsigned vwa  [3];
      int unsigned vwc  [3];
      logic [cus_pkg::PAIR_W-1:0] cur, above, above_left, left;
      cus_pkg::out_t px;
      w = clamp_dim(width_reg, cus_pkg::MAX_CHROMA_WIDTH);
      h = clamp_dim(height_reg, cus_pkg::MAX_CHROMA_HEIGHT);
      c = (col_cnt >= w) ? w - 1 : col_cnt;
      r = (row_cnt >= h) ? h - 1 : row_cnt;
      cur        = {p.v_in, p.u_in};
      above      = line_store[c];
      above_left = left_above;
      left       = left_cur;

      // Horizontal taps: edge column repeats, inner columns blend 3:1 and 1:3
      if (c == 0) begin
        hcol[0] = 0; hwl[0] = 0; hwc[0] = 4;
        nh = 1;
      end else begin
        hcol[0] = 2 * c - 1; hwl[0] = 3; hwc[0] = 1;
        hcol[1] = 2 * c;     hwl[1] = 1; hwc[1] = 3;
        nh = 2;
      end
      if (c + 1 == w) begin
        hcol[nh] = 2 * w - 1; hwl[nh] = 0; hwc[nh] = 4;
        nh++;
      end

      // Vertical taps: edge rows carry zero weights
      if (r == 0) begin
        vrow[0] = 0; vwa[0] = 0; vwc[0] = 0;
        nv = 1;
      end else begin
        vrow[0] = 2 * r - 1; vwa[0] = 3; vwc[0] = 1;
        vrow[1] = 2 * r;     vwa[1] = 1; vwc[1] = 3;
        nv = 2;
      end
      if (r + 1 == h) begin
        vrow[nv] = 2 * h - 1; vwa[nv] = 0; vwc[nv] = 0;
        nv++;
      end

      for (i = 0; i < nv; i++) begin
        for (j = 0; j < nh; j++) begin
          px.cb_out = blend_comp(left[7:0], cur[7:0], above_left[7:0], above[7:0],
                                 hwl[j], hwc[j], vwa[i], vwc[i]);
          px.cr_out = blend_comp(left[15:8], cur[15:8], above_left[15:8], above[15:8],
                                 hwl[j], hwc[j], vwa[i], vwc[i]);
          px.pixel_row = cus_pkg::POS_W'(vrow[i]);
          px.pixel_col = cus_pkg::POS_W'(hcol[j]);
          px.run_last  = (i == nv - 1) && (j == nh - 1);
          pending_pixels.push_back(px);
        end
      end

      // Advance the line store, the left samples and the counters
      left_above    = above;
      line_store[c] = cur;
      left_cur      = cur;
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
        row_cnt = r;
      end
    endfunction

    // Compare one accepted pixel with the oldest one waiting
    function void check_pixel(input cus_pkg::out_t got);
      cus_pkg::out_t exp_px;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: expected no pixel, got cb=%0d cr=%0d row=%0d col=%0d last=%0d",
                 $time, got.cb_out, got.cr_out, got.pixel_row, got.pixel_col, got.run_last);
        return;
      end
      exp_px = pending_pixels.pop_front();
      if (got.cb_out !== exp_px.cb_out || got.cr_out !== exp_px.cr_out ||
          got.pixel_row !== exp_px.pixel_row || got.pixel_col !== exp_px.pixel_col ||
          got.run_last !== exp_px.run_last) begin
        errors++;
        $display(
          "%0t: exp cb=%0d cr=%0d (%0d,%0d) last=%0d, got cb=%0d cr=%0d (%0d,%0d) last=%0d",
          $time, exp_px.cb_out, exp_px.cr_out, exp_px.pixel_row, exp_px.pixel_col,
          exp_px.run_last, got.cb_out, got.cr_out, got.pixel_row, got.pixel_col,
          got.run_last);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [cus_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cus_pkg::DIM_W-1:0]     cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  cus_pkg::in_t                  in_data;
  logic                          out_valid;
  logic                          out_ready;
  cus_pkg::out_t                 out_data;

  pixel_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_requests;
  int hold_off_served;
  int cycle_count;

  chroma_upsample_420_to_444_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if it goes far past any correct length
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** chroma_upsample_420_to_444_unit: FAILED **");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready       = 1'b0;
    hold_off_served = 0;
    forever begin
      @(posedge clk);
      if (rst_n && hold_off_served < hold_off_requests) begin
        hold_off_served++;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check every accepted pixel
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_pixel(out_data);
  end

  // Offer one pair after random idle cycles and hold it until accepted
  task automatic send_pair(input cus_pkg::in_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pair(p);
  endtask

  // Drop valid and wait until every expected pixel has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cus_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cus_pkg::DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_cfg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sample with extra weight on the range ends
  function automatic logic [cus_pkg::SAMPLE_W-1:0] pick_sample();
    int unsigned k;
    k = $urandom_range(0, 7);
    if (k == 0) return 8'd0;
    if (k == 1) return 8'd255;
    return cus_pkg::SAMPLE_W'($urandom_range(0, 255));
  endfunction

  function automatic cus_pkg::in_t random_pair();
    cus_pkg::in_t p;
    p.u_in = pick_sample();
    p.v_in = pick_sample();
    return p;
  endfunction

  // Frame size: mostly tiny, sometimes medium, rarely anything the register holds
  function automatic logic [cus_pkg::DIM_W-1:0] pick_dim(input int unsigned typ_max);
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return cus_pkg::DIM_W'($urandom_range(0, 4095));
    if (k < 4) return cus_pkg::DIM_W'($urandom_range(typ_max + 1, 24));
    return cus_pkg::DIM_W'($urandom_range(1, typ_max));
  endfunction

  // Stimulus
  initial begin
    int unsigned idle_mode, mode_items, set_idx, frame_items, n, split, k;
    logic [cus_pkg::DIM_W-1:0] w_val, h_val;
    sb                = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = cus_pkg::CFG_IDX_WIDTH;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_data           = '0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_off_requests = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size: top-left corner of a large frame
    send_pair(cus_pkg::in_t'{8'd0, 8'd255});
    send_pair(cus_pkg::in_t'{8'd255, 8'd0});
    wait_idle();

    // One by one: every pixel is an edge pixel
    write_reg(cus_pkg::CFG_IDX_WIDTH, 12'd1);
    write_reg(cus_pkg::CFG_IDX_HEIGHT, 12'd1);
    send_pair(cus_pkg::in_t'{8'd0, 8'd255});
    wait_idle();

    // Two by two, last pair makes nine pixels
    write_reg(cus_pkg::CFG_IDX_HEIGHT, 12'd2);
    write_reg(cus_pkg::CFG_IDX_WIDTH, 12'd2);
    send_pair(cus_pkg::in_t'{8'd255, 8'd0});
    send_pair(cus_pkg::in_t'{8'd0, 8'd255});
    send_pair(cus_pkg::in_t'{8'd0, 8'd0});
    send_pair(cus_pkg::in_t'{8'd255, 8'd255});
    wait_idle();

    // Three by three with spare index writes mid-frame, which must not restart it
    write_reg(cus_pkg::CFG_IDX_WIDTH, 12'd3);
    write_reg(cus_pkg::CFG_IDX_HEIGHT, 12'd3);
    for (k = 0; k < 9; k++) begin
      if (k == 2) begin
        wait_idle();
        write_reg(CFG_IDX_SPARE_LO, 12'hFFF);
        write_reg(CFG_IDX_SPARE_HI, 12'd0);
      end
      send_pair(cus_pkg::in_t'{k[0] ? 8'd255 : 8'd0, cus_pkg::SAMPLE_W'(k * 37)});
    end
    wait_idle();

    // Out-of-range and largest sizes
    write_reg(cus_pkg::CFG_IDX_WIDTH, 12'd0);
    write_reg(cus_pkg::CFG_IDX_HEIGHT, 12'd4095);
    repeat (3) send_pair(random_pair());
    wait_idle();
    write_reg(cus_pkg::CFG_IDX_WIDTH, 12'd4095);
    write_reg(cus_pkg::CFG_IDX_HEIGHT, 12'd0);
    repeat (3) send_pair(random_pair());
    wait_idle();
    write_reg(cus_pkg::CFG_IDX_WIDTH, 12'd2048);
    write_reg(cus_pkg::CFG_IDX_HEIGHT, 12'd2048);
    repeat (3) send_pair(random_pair());
    wait_idle();

    // Random frames under three idle patterns
    for (idle_mode = 0; idle_mode < 3; idle_mode++) begin
      case (idle_mode)
        0: begin send_idle_pct = 8;  recv_idle_pct = 87; end
        1: begin send_idle_pct = 87; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      mode_items = 0;
      set_idx    = 0;
      while (mode_items < RANDOM_ITEMS / 3) begin
        w_val = pick_dim(6);
        h_val = pick_dim(5);
        if ($urandom_range(0, 1)) begin
          write_reg(cus_pkg::CFG_IDX_WIDTH, w_val);
          write_reg(cus_pkg::CFG_IDX_HEIGHT, h_val);
        end else begin
          write_reg(cus_pkg::CFG_IDX_HEIGHT, h_val);
          write_reg(cus_pkg::CFG_IDX_WIDTH, w_val);
        end
        frame_items = pixel_scoreboard::clamp_dim(w_val, cus_pkg::MAX_CHROMA_WIDTH) *
                      pixel_scoreboard::clamp_dim(h_val, cus_pkg::MAX_CHROMA_HEIGHT);
        // Whole frames mostly, cut-off frames now and then
        if (frame_items > 60 || $urandom_range(0, 4) == 0)
          n = $urandom_range(1, (frame_items > 60) ? 60 : frame_items);
        else
          n = frame_items * $urandom_range(1, 2);
        // Stall the receiver while requests keep coming so the block backs up
        if (set_idx == 0) begin
          hold_off_requests++;
          n += 16;
        end
        split = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n) : n;
        for (k = 0; k < n; k++) begin
          if (k == split) begin
            wait_idle();
            write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO,
                      cus_pkg::DIM_W'($urandom_range(0, 4095)));
          end
          send_pair(random_pair());
        end
        wait_idle();
        mode_items += n;
        set_idx++;
      end
    end

    // Drain, then watch for stray pixels
    wait_idle();
    repeat (END_QUIET_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** chroma_upsample_420_to_444_unit: PASSED **");
    end else begin
      $display("** chroma_upsample_420_to_444_unit: FAILED **");
    end
    $finish;
  end

endmodule
